[hw/rtl/fl64v_pkg.sv]
package fl64v_pkg;

	localparam logic [31:0] FlMod = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] low_sum;
		logic [31:0] high_sum;
		logic [63:0] stored;
		logic        long_enough;
		logic        header_ok;
	} fl64v_obj_t;

	// sum of two values modulo 2^32-1, a below the modulus, b at most the modulus
	function automatic logic [31:0] mod_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, FlMod}) begin
			s = s - {1'b0, FlMod};
		end
		return s[31:0];
	endfunction

endpackage

[hw/rtl/fletcher64_object_checksum_verify_top.sv]
// channel  handshake             payload
// in       in_valid / in_ready   word, last_word
// out      out_valid / out_ready checksum, match, too_short
//
// one word accepted per cycle while in_ready is high; a result passes valid_s1, valid_s2, then out_valid
// sums update once per accepted word, check halves over the next two stages
// whole pipeline holds while a result waits and out_ready is low
// reset clears sums, stored checksum, word count and all valid flags
module fletcher64_object_checksum_verify_top #(
	parameter int SKIP_WORDS   = 2,
	parameter int HEADER_WORDS = 8,
	parameter int MAX_WORDS    = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] checksum,
	output logic        match,
	output logic        too_short
);
	import fl64v_pkg::*;

	logic       en;
	logic       valid_s1;
	fl64v_obj_t obj_s1;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	fl64v_accum #(
		.SKIP_WORDS  (SKIP_WORDS),
		.HEADER_WORDS(HEADER_WORDS),
		.MAX_WORDS   (MAX_WORDS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.word     (word),
		.last_word(last_word),
		.valid_s1 (valid_s1),
		.obj_s1   (obj_s1)
	);

	fl64v_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_s1   (valid_s1),
		.obj_s1     (obj_s1),
		.valid_q    (out_valid),
		.checksum_q (checksum),
		.match_q    (match),
		.too_short_q(too_short)
	);

	a_match_not_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match |-> !too_short)
		else $error("match with short object");

	a_last_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_word |=> valid_s1)
		else $error("last word lost");

	a_long_has_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !too_short |-> checksum[31:0] != 32'd0)
		else $error("zero first check half on long object");

endmodule

[hw/rtl/fl64v_accum.sv]
module fl64v_accum #(
	parameter int SKIP_WORDS   = 2,
	parameter int HEADER_WORDS = 8,
	parameter int MAX_WORDS    = 16384
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            word,
	input  logic                   last_word,
	output logic                   valid_s1,
	output fl64v_pkg::fl64v_obj_t  obj_s1
);
	import fl64v_pkg::*;

	localparam int IdxW = $clog2(MAX_WORDS + 1);

	logic [31:0]     low_q;
	logic [31:0]     high_q;
	logic [63:0]     stored_q;
	logic [IdxW-1:0] idx_q;

	logic            accept;
	logic [31:0]     low_d;
	logic [31:0]     high_d;
	logic [63:0]     stored_d;
	logic [IdxW-1:0] count;

	assign accept = in_valid && en;

	always_comb begin
		low_d    = low_q;
		high_d   = high_q;
		stored_d = stored_q;
		if (idx_q < IdxW'(SKIP_WORDS)) begin
			if (idx_q == '0) begin
				stored_d[31:0] = word;
			end else if (idx_q == IdxW'(1)) begin
				stored_d[63:32] = word;
			end
		end else begin
			low_d  = mod_add(low_q, word);
			high_d = mod_add(high_q, low_d);
		end
		count = (idx_q >= IdxW'(MAX_WORDS)) ? IdxW'(MAX_WORDS) : idx_q + IdxW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			high_q   <= '0;
			stored_q <= '0;
			idx_q    <= '0;
		end else if (accept) begin
			if (last_word) begin
				low_q    <= '0;
				high_q   <= '0;
				stored_q <= '0;
				idx_q    <= '0;
			end else begin
				low_q    <= low_d;
				high_q   <= high_d;
				stored_q <= stored_d;
				idx_q    <= count;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && last_word;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_word) begin
			obj_s1.low_sum     <= low_d;
			obj_s1.high_sum    <= high_d;
			obj_s1.stored      <= stored_d;
			obj_s1.long_enough <= count > IdxW'(SKIP_WORDS);
			obj_s1.header_ok   <= count > IdxW'(HEADER_WORDS);
		end
	end

endmodule

[hw/rtl/fl64v_check.sv]
module fl64v_check (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_s1,
	input  fl64v_pkg::fl64v_obj_t  obj_s1,
	output logic                   valid_q,
	output logic [63:0]            checksum_q,
	output logic                   match_q,
	output logic                   too_short_q
);
	import fl64v_pkg::*;

	logic        valid_s2;
	logic [31:0] c1_s2;
	logic [31:0] low_s2;
	logic [63:0] stored_s2;
	logic        long_s2;
	logic        hdr_s2;

	logic [31:0] c1;
	logic [31:0] c2;
	logic [63:0] sum;

	assign c1  = FlMod - mod_add(obj_s1.low_sum, obj_s1.high_sum);
	assign c2  = FlMod - mod_add(low_s2, c1_s2);
	assign sum = long_s2 ? {c2, c1_s2} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s2       <= c1;
			low_s2      <= obj_s1.low_sum;
			stored_s2   <= obj_s1.stored;
			long_s2     <= obj_s1.long_enough;
			hdr_s2      <= obj_s1.header_ok;
			checksum_q  <= sum;
			match_q     <= hdr_s2 && (sum == stored_s2);
			too_short_q <= !hdr_s2;
		end
	end

endmodule
